// ===== rtl/khash_pkg.sv =====
// shared types and constants of the keyed word stream hash
`default_nettype none

package khash_pkg;

   // mixing constants
   localparam logic [63:0] HASH_M = 64'h880355f21e6d1965;
   localparam logic [63:0] HASH_F = 64'h2127599bf4325c37;
   localparam int MIX_SHIFT = 23;
   localparam int FIN_SHIFT = 47;

   // key length that selects the product hash
   localparam logic [15:0] PRODUCT_LEN = 16'd16;

   // bytes in one key word
   localparam logic [3:0] WORD_BYTES = 4'd8;

   // front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // one unit of work for the back end
   typedef struct packed {
      logic        seed;     // reload running hash from key length
      logic        mix;      // mix word_a into running hash
      logic        fin;      // finalize and emit
      logic        prod;     // emit folded product of word_a and word_b
      logic [15:0] key_len;
      logic [63:0] word_a;
      logic [63:0] word_b;
   } op_type;

   // request to the shared multiplier
   typedef struct packed {
      logic        start;
      logic        full;     // 1: full 128-bit product, 0: low 64 bits only
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

// ===== rtl/khash_front.sv =====
// front end: accepts key words, tracks product mode and builds back-end work items
`default_nettype none

module khash_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [63:0]        req_key_word,
   input  wire logic [3:0]         req_valid_bytes,
   input  wire logic [15:0]        req_key_length,
   input  wire logic               req_first_word,
   input  wire logic               req_last_word,
   output logic                    op_valid,
   input  wire logic               op_ready,
   output khash_pkg::op_type       op_data
);

   logic        product_mode_ff, product_mode_in;
   logic [63:0] held_ff, held_in;
   logic [3:0]  nbytes;
   logic [63:0] byte_mask;
   logic        accept;
   logic        needs_work;

   always_comb begin
      nbytes = (req_valid_bytes > khash_pkg::WORD_BYTES) ? khash_pkg::WORD_BYTES
                                                         : req_valid_bytes;
      for (int i = 0; i < 8; i++) begin
         byte_mask[i*8 +: 8] = (4'(i) < nbytes) ? 8'hff : 8'h00;
      end
   end

   // mode of this word: a first word decides it from the length
   always_comb begin
      product_mode_in = req_first_word ? (req_key_length == khash_pkg::PRODUCT_LEN)
                                       : product_mode_ff;
      held_in = held_ff;
      if (product_mode_in && (req_first_word || !req_last_word)) begin
         held_in = req_key_word;
      end
   end

   always_comb begin
      op_data = '0;
      op_data.key_len = req_key_length;
      if (product_mode_in) begin
         op_data.prod   = 1'b1;
         op_data.word_a = req_first_word ? req_key_word : held_ff;
         op_data.word_b = req_key_word;
         needs_work     = req_last_word;
      end else begin
         op_data.seed   = req_first_word;
         op_data.mix    = (nbytes != 4'd0);
         op_data.fin    = req_last_word;
         op_data.word_a = req_key_word & byte_mask;
         needs_work     = req_first_word || (nbytes != 4'd0) || req_last_word;
      end
   end

   assign req_ready = op_ready;
   assign op_valid  = req_valid && needs_work;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         product_mode_ff <= 1'b0;
         held_ff         <= '0;
      end else if (accept) begin
         product_mode_ff <= product_mode_in;
         held_ff         <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/khash_queue.sv =====
// short work queue between front and back end
`default_nettype none

module khash_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire khash_pkg::op_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output khash_pkg::op_type       out_data
);

   khash_pkg::op_type                  entry_ff [khash_pkg::QUEUE_DEPTH];
   logic [khash_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [khash_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [khash_pkg::QUEUE_PTR_W:0]    count_ff, count_in;
   logic                               push, pop;

   assign in_ready  = (count_ff != (khash_pkg::QUEUE_PTR_W+1)'(khash_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (khash_pkg::QUEUE_PTR_W+1)'(khash_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> out_valid)
      else $error("back end pops an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/khash_mul.sv =====
// iterative 64x64 multiplier built on one 32x32 multiplier
`default_nettype none

module khash_mul (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire khash_pkg::mul_req_type req,
   output logic                        done,
   output logic [127:0]                result
);

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic         full_ff, full_in;
   logic         busy_ff, busy_in;
   logic [1:0]   step_ff, step_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pstep_ff, pstep_in;
   logic         pvalid_ff, pvalid_in;
   logic         plast_ff, plast_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic         last_step;
   logic [127:0] aligned;

   // partial order: a0*b0, a0*b1, a1*b0, a1*b1
   assign a_half    = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half    = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign last_step = full_ff ? (step_ff == 2'd3) : (step_ff == 2'd2);

   always_comb begin
      case (pstep_ff)
         2'd0:    aligned = {64'd0, prod_ff};
         2'd3:    aligned = {prod_ff, 64'd0};
         default: aligned = {32'd0, prod_ff, 32'd0};
      endcase
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      full_in   = full_ff;
      busy_in   = busy_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      prod_in   = 64'(a_half) * 64'(b_half);
      pstep_in  = step_ff;
      pvalid_in = busy_ff;
      plast_in  = busy_ff && last_step;
      done_in   = pvalid_ff && plast_ff;
      if (pvalid_ff) begin
         acc_in = acc_ff + aligned;
      end
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         full_in = req.full;
         busy_in = 1'b1;
         step_in = 2'd0;
         acc_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      full_ff  <= full_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      pstep_ff <= pstep_in;
      plast_ff <= plast_in;
      acc_ff   <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         pvalid_ff <= pvalid_in;
         done_ff   <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (!busy_ff && !pvalid_ff))
      else $error("multiplier started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held past one cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/khash_back.sv =====
// back end: sequences mixing, finalizer and product hash over the shared multiplier
`default_nettype none

module khash_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_valid,
   output logic                    op_ready,
   input  wire khash_pkg::op_type  op_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_hash_value
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_NEXT = 8'b0000_0010,
      ST_SEED = 8'b0000_0100,
      ST_MIX1 = 8'b0000_1000,
      ST_MIX2 = 8'b0001_0000,
      ST_MIX3 = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_PROD = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   khash_pkg::op_type      op_ff, op_in;
   logic [63:0]            hash_ff, hash_in;
   logic [63:0]            rsp_hash_ff, rsp_hash_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_pending_ff, out_pending_in;
   logic [63:0]            result_ff, result_in;
   khash_pkg::mul_req_type mul_req;
   logic                   mul_done;
   logic [127:0]           mul_result;
   logic [63:0]            mul_lo;
   logic                   out_free;

   khash_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_result)
   );

   assign mul_lo   = mul_result[63:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      hash_in        = hash_ff;
      result_in      = result_ff;
      out_pending_in = out_pending_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hash_in    = rsp_hash_ff;
      mul_req        = '0;
      op_ready       = 1'b0;

      // a finished hash waits here until the output register frees up
      if (out_pending_ff && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_hash_in    = result_ff;
         out_pending_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && !out_pending_ff) begin
               op_ready = 1'b1;
               op_in    = op_data;
               if (op_data.prod) begin
                  mul_req.start = 1'b1;
                  mul_req.full  = 1'b1;
                  mul_req.a     = op_data.word_a;
                  mul_req.b     = op_data.word_b;
                  state_in      = ST_PROD;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            mul_req.b = khash_pkg::HASH_M;
            if (op_ff.seed) begin
               mul_req.start = 1'b1;
               mul_req.a     = {48'd0, op_ff.key_len};
               op_in.seed    = 1'b0;
               state_in      = ST_SEED;
            end else if (op_ff.mix) begin
               mul_req.start = 1'b1;
               mul_req.a     = op_ff.word_a;
               op_in.mix     = 1'b0;
               state_in      = ST_MIX1;
            end else if (op_ff.fin) begin
               mul_req.start = 1'b1;
               mul_req.a     = hash_ff ^ (hash_ff >> khash_pkg::MIX_SHIFT);
               mul_req.b     = khash_pkg::HASH_F;
               op_in.fin     = 1'b0;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEED: begin
            if (mul_done) begin
               hash_in  = mul_lo;
               state_in = ST_NEXT;
            end
         end
         ST_MIX1: begin
            // k ^= k >> 23, then second multiply
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_lo ^ (mul_lo >> khash_pkg::MIX_SHIFT);
               mul_req.b     = khash_pkg::HASH_M;
               state_in      = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = hash_ff ^ mul_lo;
               mul_req.b     = khash_pkg::HASH_M;
               state_in      = ST_MIX3;
            end
         end
         ST_MIX3: begin
            if (mul_done) begin
               hash_in  = mul_lo;
               state_in = ST_NEXT;
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               result_in      = mul_lo ^ (mul_lo >> khash_pkg::FIN_SHIFT);
               out_pending_in = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_PROD: begin
            if (mul_done) begin
               result_in      = mul_result[63:0] ^ mul_result[127:64];
               out_pending_in = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      result_ff   <= result_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hash_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         out_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hash_ff        <= hash_in;
         rsp_valid_ff   <= rsp_valid_in;
         out_pending_ff <= out_pending_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

// ===== rtl/keyed_word_stream_hash64.sv =====
// top level of the keyed word stream hash (fasthash64 variant with 16-byte product hash)
`default_nettype none

// Hashes a key streamed as little-endian 64-bit words, one word per req_ transfer, and
// returns one 64-bit hash per rsp_ transfer when a word marked last completes a key.
// The first word of a key carries the total length: length 16 selects the product hash
// (low half XOR high half of the 128-bit product of the two words), any other length
// runs fasthash64 seeded with length times M, with each word masked to its valid bytes.
// A front end classifies each word and drops work items into a two-deep queue; a back
// end runs them through one shared 32x32 multiplier that builds each 64-bit product in
// three partial products (four for the full 128-bit product), registering each partial
// product before adding it into the accumulator. That multiplier sets the rate: a word
// that holds key bytes takes three multiplies, a first word one more for the seed and a
// last word one more for the finalizer; in a 16-byte key the first word costs nothing
// and the last one full multiply. Words with no bytes that are neither first nor last
// take no back-end time. A finished hash sits in an output register, so the back end
// keeps working while it waits to be taken (a second finished hash holds it until then),
// and the queue lets the front end take words while the back end is busy.

module keyed_word_stream_hash64 (
   input  wire logic        clock,
   input  wire logic        reset,
   // key word input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_key_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic [15:0] req_key_length,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   // hash output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value
);

   // front end to queue
   logic              fq_valid, fq_ready;
   khash_pkg::op_type fq_data;
   // queue to back end
   logic              qb_valid, qb_ready;
   khash_pkg::op_type qb_data;

   // classify words, hold the first word of a product key
   khash_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_key_length  (req_key_length),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .op_valid        (fq_valid),
      .op_ready        (fq_ready),
      .op_data         (fq_data)
   );

   // decouples word intake from the multiply sequence
   khash_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // seed, mix, finalize and product over the shared multiplier
   khash_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (qb_valid),
      .op_ready       (qb_ready),
      .op_data        (qb_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire
